// ===== design/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

`endif

// ===== design/mbr_pkg.sv =====
// shared types, codes and constants of the msb-first bit reader
package mbr_pkg;

    // parameter defaults
    localparam int DEF_STORE_BYTES   = 4096;
    localparam int DEF_COUNTER_SLOTS = 4;
    localparam int DEF_MAX_READ_BITS = 64;

    // field widths
    localparam int OP_W       = 3;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int SKIP_W     = 8;
    localparam int SLOT_W     = 3;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 32;
    localparam int IN_DATA_W  = 32;
    localparam int PEEK_BYTES = 3;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 3'd0,
        OP_GET     = 3'd1,
        OP_SKIP    = 3'd2,
        OP_PEEK    = 3'd3,
        OP_RST_CNT = 3'd4,
        OP_RD_CNT  = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_NOP     = 3'd7
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EOD   = 2'd1,
        STAT_ALIGN = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_BITS,
        ST_FETCH_WAIT,
        ST_PEEK_RD,
        ST_PEEK_WAIT,
        ST_WRAP,
        ST_DONE
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic exec;
        logic bits_step;
        logic fetch;
        logic fetch_load;
        logic peek_rd;
        logic peek_load;
        logic wrap_step;
        logic result;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        op_t  op;
        logic go;
        logic rem_zero;
        logic rc_zero;
        logic peek_last;
        logic wrap_need;
        logic out_free;
    } stat_t;

endpackage

// ===== design/mbr_ctrl.sv =====
// controller state machine of the msb-first bit reader
module mbr_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mbr_pkg::stat_t st,
    output mbr_pkg::cmd_t  cmd
);
    import mbr_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                if (st.go)
                begin
                    case (st.op)
                        OP_GET:  state_next = ST_BITS;
                        OP_PEEK: state_next = ST_PEEK_RD;
                        OP_SKIP: state_next = ST_WRAP;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_BITS:
            begin
                if (st.rem_zero)
                begin
                    state_next = ST_DONE;
                end
                else if (st.rc_zero)
                begin
                    state_next = ST_FETCH_WAIT;
                end
            end
            ST_FETCH_WAIT:
            begin
                state_next = ST_BITS;
            end
            ST_PEEK_RD:
            begin
                state_next = ST_PEEK_WAIT;
            end
            ST_PEEK_WAIT:
            begin
                state_next = st.peek_last ? ST_DONE : ST_PEEK_RD;
            end
            ST_WRAP:
            begin
                if (!st.wrap_need)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = in_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            ST_BITS:
            begin
                cmd.bits_step = !st.rem_zero && !st.rc_zero;
                cmd.fetch     = !st.rem_zero && st.rc_zero;
            end
            ST_FETCH_WAIT:
            begin
                cmd.fetch_load = 1'b1;
            end
            ST_PEEK_RD:
            begin
                cmd.peek_rd = 1'b1;
            end
            ST_PEEK_WAIT:
            begin
                cmd.peek_load = 1'b1;
            end
            ST_WRAP:
            begin
                cmd.wrap_step = st.wrap_need;
            end
            ST_DONE:
            begin
                cmd.result = st.out_free;
                in_ready   = st.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.capture = in_ready && in_valid;
    end

endmodule

// ===== design/mbr_dp.sv =====
// datapath of the msb-first bit reader: byte store, residual byte, counters, result register
module mbr_dp
#(
    parameter int STORE_BYTES   = mbr_pkg::DEF_STORE_BYTES,
    parameter int COUNTER_SLOTS = mbr_pkg::DEF_COUNTER_SLOTS,
    parameter int MAX_READ_BITS = mbr_pkg::DEF_MAX_READ_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_data,
    input  mbr_pkg::op_t                  in_op,
    input  logic [mbr_pkg::BYTE_W-1:0]    in_data_byte,
    input  logic [mbr_pkg::COUNT_W-1:0]   in_bit_count,
    input  logic [mbr_pkg::SKIP_W-1:0]    in_skip_length,
    input  logic [mbr_pkg::SLOT_W-1:0]    in_counter_slot,
    input  mbr_pkg::cmd_t                 cmd,
    output mbr_pkg::stat_t                st,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [mbr_pkg::VALUE_W-1:0]   out_value,
    output mbr_pkg::status_t              out_status
);
    import mbr_pkg::*;

    localparam int AW   = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int FW   = $clog2(STORE_BYTES + 1);
    localparam int SW   = $clog2(2 * STORE_BYTES + 256);
    localparam int AVW  = SW + 4;
    localparam int SIW  = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;
    localparam int ADDW = SKIP_W + 3;

    // captured item
    op_t                op_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SKIP_W-1:0]  skip_reg;
    logic [SLOT_W-1:0]  slot_reg;

    // reader state
    logic               eof_en_reg;
    logic [FW-1:0]      fill_reg,  fill_next;
    logic [SW-1:0]      ri_reg,    ri_next;
    logic [BYTE_W-1:0]  res_reg,   res_next;
    logic [3:0]         rc_reg,    rc_next;
    logic [COUNT_W-1:0] rem_reg,   rem_next;
    logic [VALUE_W-1:0] acc_reg,   acc_next;
    status_t            stat_reg,  stat_next;
    logic [1:0]         pk_reg,    pk_next;
    logic [CNT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   slots_reg  [COUNTER_SLOTS];
    logic [CNT_W-1:0]   slots_next [COUNTER_SLOTS];

    // byte store
    logic [BYTE_W-1:0]  mem [STORE_BYTES];
    logic [BYTE_W-1:0]  rdata_reg;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      fetch_addr;
    logic [AW-1:0]      peek_addr;
    logic [SW-1:0]      peek_idx;

    // out register
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    status_t            out_status_reg;

    // decode helpers
    logic [COUNT_W-1:0] n_eff;
    logic [SW-1:0]      bytes_left;
    logic [AVW-1:0]     avail_bits;
    logic               get_eod;
    logic               skip_eod;
    logic               peek_eod;
    logic               aligned;
    logic               is_full;
    status_t            exec_status;
    logic               go;
    logic               slot_in_range;
    logic               slot_is_total;
    logic [SIW-1:0]     slot_idx;
    logic [CNT_W-1:0]   cnt_rd;
    logic [3:0]         take_k;
    logic [3:0]         rc_left;
    logic [BYTE_W-1:0]  taken;
    logic               add_en;
    logic [ADDW-1:0]    add_amt;
    logic               do_skip;
    logic               do_load;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_op;
            data_reg  <= in_data_byte;
            count_reg <= in_bit_count;
            skip_reg  <= in_skip_length;
            slot_reg  <= in_counter_slot;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eof_en_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            eof_en_reg <= cfg_data;
        end
    end

    // availability checks
    always_comb
    begin
        n_eff      = (count_reg > COUNT_W'(MAX_READ_BITS)) ? COUNT_W'(MAX_READ_BITS) : count_reg;
        bytes_left = (SW'(fill_reg) > ri_reg) ? SW'(fill_reg) - ri_reg : '0;
        avail_bits = AVW'(rc_reg) + AVW'({bytes_left, 3'b000});
        get_eod    = eof_en_reg && (AVW'(n_eff) > avail_bits);
        skip_eod   = eof_en_reg && (SW'(skip_reg) > bytes_left);
        peek_eod   = eof_en_reg && (bytes_left < SW'(PEEK_BYTES));
        aligned    = (rc_reg == 4'd0);
        is_full    = (fill_reg >= FW'(STORE_BYTES));
    end

    // per-operation status and go decision
    always_comb
    begin
        exec_status = STAT_OK;
        go          = 1'b0;
        unique case (op_reg)
            OP_LOAD:
            begin
                if (is_full)
                begin
                    exec_status = STAT_FULL;
                end
            end
            OP_GET:
            begin
                if (n_eff == '0)
                begin
                    go = 1'b0;
                end
                else if (get_eod)
                begin
                    exec_status = STAT_EOD;
                end
                else
                begin
                    go = 1'b1;
                end
            end
            OP_SKIP, OP_PEEK:
            begin
                if (!aligned)
                begin
                    exec_status = STAT_ALIGN;
                end
                else if ((op_reg == OP_SKIP) ? skip_eod : peek_eod)
                begin
                    exec_status = STAT_EOD;
                end
                else
                begin
                    go = 1'b1;
                end
            end
            OP_RST_CNT, OP_RD_CNT, OP_CLEAR, OP_NOP:
            begin
                go = 1'b0;
            end
            default:
            begin
                go = 1'b0;
            end
        endcase
    end

    // counter slot select
    always_comb
    begin
        slot_in_range = int'(slot_reg) < COUNTER_SLOTS;
        slot_is_total = int'(slot_reg) == COUNTER_SLOTS;
        slot_idx      = SIW'(slot_reg);
        if (slot_in_range)
        begin
            cnt_rd = slots_reg[slot_idx];
        end
        else if (slot_is_total)
        begin
            cnt_rd = total_reg;
        end
        else
        begin
            cnt_rd = '0;
        end
    end

    // bit extraction from the residual byte
    always_comb
    begin
        take_k  = (rem_reg < COUNT_W'(rc_reg)) ? rem_reg[3:0] : rc_reg;
        rc_left = rc_reg - take_k;
        taken   = (res_reg >> rc_left) & (8'hFF >> (4'd8 - take_k));
    end

    // store addresses, read index kept below twice the store size
    always_comb
    begin
        fetch_addr = (ri_reg >= SW'(STORE_BYTES)) ? AW'(ri_reg - SW'(STORE_BYTES))
                                                  : AW'(ri_reg);
        peek_idx   = ri_reg + SW'(pk_reg);
        if (peek_idx >= SW'(2 * STORE_BYTES))
        begin
            peek_addr = AW'(peek_idx - SW'(2 * STORE_BYTES));
        end
        else if (peek_idx >= SW'(STORE_BYTES))
        begin
            peek_addr = AW'(peek_idx - SW'(STORE_BYTES));
        end
        else
        begin
            peek_addr = AW'(peek_idx);
        end
        rd_addr = cmd.peek_rd ? peek_addr : fetch_addr;
    end

    assign do_skip = cmd.exec && go && (op_reg == OP_SKIP);
    assign do_load = cmd.exec && (op_reg == OP_LOAD) && !is_full;

    // byte store write and registered read
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            mem[AW'(fill_reg)] <= data_reg;
        end
        if (cmd.fetch || cmd.peek_rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // reader state next values
    always_comb
    begin
        fill_next = fill_reg;
        ri_next   = ri_reg;
        res_next  = res_reg;
        rc_next   = rc_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        stat_next = stat_reg;
        pk_next   = pk_reg;
        if (cmd.exec)
        begin
            stat_next = exec_status;
            rem_next  = n_eff;
            pk_next   = '0;
            acc_next  = (op_reg == OP_RD_CNT) ? VALUE_W'(cnt_rd) : '0;
            if (do_load)
            begin
                fill_next = fill_reg + FW'(1);
            end
            if (do_skip)
            begin
                ri_next = ri_reg + SW'(skip_reg);
            end
            if (op_reg == OP_CLEAR)
            begin
                ri_next  = '0;
                res_next = '0;
                rc_next  = '0;
            end
        end
        if (cmd.bits_step)
        begin
            acc_next = (acc_reg << take_k) | VALUE_W'(taken);
            rem_next = rem_reg - COUNT_W'(take_k);
            rc_next  = rc_left;
        end
        if (cmd.fetch_load)
        begin
            res_next = rdata_reg;
            rc_next  = 4'd8;
            ri_next  = (ri_reg == SW'(2 * STORE_BYTES - 1)) ? '0 : ri_reg + SW'(1);
        end
        if (cmd.peek_load)
        begin
            acc_next = {acc_reg[VALUE_W-BYTE_W-1:0], rdata_reg};
            pk_next  = pk_reg + 2'd1;
        end
        if (cmd.wrap_step)
        begin
            ri_next = ri_reg - SW'(2 * STORE_BYTES);
        end
    end

    // bit counters
    always_comb
    begin
        add_en     = do_skip || cmd.bits_step;
        add_amt    = do_skip ? {skip_reg, 3'b000} : ADDW'(take_k);
        total_next = total_reg;
        for (int i = 0; i < COUNTER_SLOTS; i++)
        begin
            slots_next[i] = slots_reg[i];
        end
        if (add_en)
        begin
            total_next = total_reg + CNT_W'(add_amt);
            for (int i = 0; i < COUNTER_SLOTS; i++)
            begin
                slots_next[i] = slots_reg[i] + CNT_W'(add_amt);
            end
        end
        if (cmd.exec && (op_reg == OP_RST_CNT))
        begin
            if (slot_in_range)
            begin
                slots_next[slot_idx] = '0;
            end
            else if (slot_is_total)
            begin
                total_next = '0;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            ri_reg    <= '0;
            res_reg   <= '0;
            rc_reg    <= '0;
            rem_reg   <= '0;
            pk_reg    <= '0;
            total_reg <= '0;
            for (int i = 0; i < COUNTER_SLOTS; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else
        begin
            fill_reg  <= fill_next;
            ri_reg    <= ri_next;
            res_reg   <= res_next;
            rc_reg    <= rc_next;
            rem_reg   <= rem_next;
            pk_reg    <= pk_next;
            total_reg <= total_next;
            for (int i = 0; i < COUNTER_SLOTS; i++)
            begin
                slots_reg[i] <= slots_next[i];
            end
        end
    end

    // result payload of the current item
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        stat_reg <= stat_next;
    end

    // output register, holds a finished result until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            out_value_reg  <= acc_reg;
            out_status_reg <= stat_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    // status toward the controller
    always_comb
    begin
        st.op        = op_reg;
        st.go        = go;
        st.rem_zero  = (rem_reg == '0);
        st.rc_zero   = aligned;
        st.peek_last = (pk_reg == 2'(PEEK_BYTES - 1));
        st.wrap_need = (ri_reg >= SW'(2 * STORE_BYTES));
        st.out_free  = !out_valid_reg || out_ready;
    end

endmodule

// ===== design/msb_first_bit_reader.sv =====
// load, counter, clear, zero-bit get and failed items pass through EXEC and DONE after acceptance;
// get bits adds BITS steps on the residual byte and a FETCH_WAIT for each byte fetched;
// peek runs PEEK_RD and PEEK_WAIT per byte, skip adds WRAP steps; one item in flight, set by the fetch loop
// and the single read port of the byte store; a result waits in the output register
// reset (async, active low) clears control, counters and fill level, turns eof check on;
// the byte store is not cleared
module msb_first_bit_reader
#(
    parameter int STORE_BYTES   = mbr_pkg::DEF_STORE_BYTES,
    parameter int COUNTER_SLOTS = mbr_pkg::DEF_COUNTER_SLOTS,
    parameter int MAX_READ_BITS = mbr_pkg::DEF_MAX_READ_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write: eof_check_enable
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,
    // input transactions
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // data_byte[7:0], bit_count[14:8], skip_length[22:15], counter_slot[25:23], zero fill
    input  logic [mbr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // operation[2:0]
    input  logic [mbr_pkg::OP_W-1:0]         s_axis_tuser,
    // result transactions
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // value[63:0]
    output logic [mbr_pkg::VALUE_W-1:0]      m_axis_tdata,
    // status[1:0]
    output logic [mbr_pkg::STATUS_W-1:0]     m_axis_tuser
);
    import mbr_pkg::*;

    localparam int BC_LSB   = BYTE_W;
    localparam int SKIP_LSB = BC_LSB + COUNT_W;
    localparam int SLOT_LSB = SKIP_LSB + SKIP_W;

    cmd_t    cmd;
    stat_t   st;
    status_t out_status;

    assign cfg_ready = 1'b1;

    mbr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mbr_dp
    #(
        .STORE_BYTES   (STORE_BYTES),
        .COUNTER_SLOTS (COUNTER_SLOTS),
        .MAX_READ_BITS (MAX_READ_BITS)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .in_op           (op_t'(s_axis_tuser)),
        .in_data_byte    (s_axis_tdata[BYTE_W-1:0]),
        .in_bit_count    (s_axis_tdata[SKIP_LSB-1:BC_LSB]),
        .in_skip_length  (s_axis_tdata[SLOT_LSB-1:SKIP_LSB]),
        .in_counter_slot (s_axis_tdata[SLOT_LSB+SLOT_W-1:SLOT_LSB]),
        .cmd             (cmd),
        .st              (st),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_value       (m_axis_tdata),
        .out_status      (out_status)
    );

    assign m_axis_tuser = out_status;

endmodule

// ===== design/mbr_chk.sv =====
// port-level checker of the msb-first bit reader and its bind
`include "assert_macros.svh"

module mbr_chk
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mbr_pkg::VALUE_W-1:0]   m_axis_tdata,
    input logic [mbr_pkg::STATUS_W-1:0]  m_axis_tuser
);
    import mbr_pkg::*;

    logic out_stall;

    // result offered but not taken
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    // a pending result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid)

    // a stalled result keeps its payload
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // any failing status comes with a zero value
    `ASSERT_SAME(a_err_zero, clk, rst_n, m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tdata == '0)

    // one item at a time: no input transaction right after one is taken
    `ASSERT_NEXT(a_one_item, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind msb_first_bit_reader mbr_chk u_mbr_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
